/* hw/rtl/timer_expiry_table_defines.svh */
// Assertion macros for the timer table.
`ifndef TIMER_EXPIRY_TABLE_DEFINES_SVH
`define TIMER_EXPIRY_TABLE_DEFINES_SVH
`ifndef SYNTH
`define TET_ASSERT(lbl, ck, rs, prop) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) \
    else $error("timer table assertion failed");
`define TET_ASSERT_ALWAYS(lbl, ck, prop) \
  lbl: assert property (@(posedge ck) prop) \
    else $error("timer table assertion failed");
`else
`define TET_ASSERT(lbl, ck, rs, prop)
`define TET_ASSERT_ALWAYS(lbl, ck, prop)
`endif
`endif

/* hw/rtl/tet_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package tet_pkg;
  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_CANCEL = 2'd1;
  localparam logic [1:0] CMD_CHECK = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  localparam logic [1:0] KIND_EXPIRY = 2'd0;
  localparam logic [1:0] KIND_CANCEL = 2'd1;
  localparam logic [1:0] KIND_CLOSE = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NULL_OWNER = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic        null_owner;
    logic [15:0] owner;
    logic [31:0] time_value;
    logic        notify;
    logic [31:0] data;
  } cmd_t;

  typedef struct packed {
    logic [15:0] owner;
    logic [31:0] expiry;
    logic [31:0] data;
    logic        notify;
  } slot_t;
endpackage
`default_nettype wire

/* hw/rtl/tet_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module tet_front (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cmd_valid,
  output logic              cmd_ready,
  input  wire logic [1:0]   command,
  input  wire logic [15:0]  owner,
  input  wire logic [31:0]  time_value,
  input  wire logic         has_callback,
  input  wire logic [31:0]  data_tag,
  output logic              q_valid,
  input  wire logic         q_pop,
  output tet_pkg::cmd_t     q_data
);
  import tet_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  cmd_t             mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [PTR_W:0]   fill;
  cmd_t             entry;
  logic             push;

  always_comb begin
    entry.op = command;
    entry.null_owner = (owner == 16'd0);
    entry.owner = owner;
    entry.time_value = time_value;
    entry.notify = has_callback;
    entry.data = data_tag;
  end

  assign cmd_ready = (fill != (PTR_W + 1)'(QUEUE_DEPTH));
  assign push = cmd_valid && cmd_ready;
  assign q_valid = (fill != '0);
  assign q_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= entry;
    end
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (q_pop) begin
        rptr <= (rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      fill <= fill + (PTR_W + 1)'(push) - (PTR_W + 1)'(q_pop);
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/tet_back.sv */
`timescale 1ns / 1ps
`default_nettype none
module tet_back (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         q_valid,
  output logic              q_pop,
  input  wire tet_pkg::cmd_t q_data,
  output logic              res_valid,
  input  wire logic         res_ready,
  output logic [1:0]        kind,
  output logic [15:0]       owner_out,
  output logic [31:0]       fire_time,
  output logic [31:0]       data_out,
  output logic [1:0]        status,
  output logic              last
);
  import tet_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_CLOSE = 3'b100
  } state_t;

  state_t           state;
  cmd_t             cur;
  logic [1:0]       cur_status;
  slot_t            tbl [TABLE_DEPTH];
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] rd;
  logic [CNT_W-1:0] wr;
  logic             can_load;
  slot_t            rd_slot;
  logic             hit;
  logic             res_load;

  assign can_load = !res_valid || res_ready;
  assign q_pop = (state == S_IDLE) && q_valid;
  assign rd_slot = tbl[rd[IDX_W-1:0]];
  assign hit = (cur.op == CMD_CANCEL) ? (rd_slot.owner == cur.owner)
                                      : (rd_slot.expiry < cur.time_value);
  assign res_load = can_load && ((state == S_CLOSE) ||
                    ((state == S_SCAN) && (rd != count) && hit && rd_slot.notify));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready && !res_load) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur <= q_data;
            cur_status <= ST_OK;
            rd <= '0;
            wr <= '0;
            state <= S_CLOSE;
            case (q_data.op)
              CMD_ADD: begin
                if (q_data.null_owner) begin
                  cur_status <= ST_NULL_OWNER;
                end else if (count == CNT_W'(TABLE_DEPTH)) begin
                  cur_status <= ST_FULL;
                end else begin
                  for (int i = 1; i < TABLE_DEPTH; i++) begin
                    tbl[i] <= tbl[i-1];
                  end
                  tbl[0] <= '{owner: q_data.owner, expiry: q_data.time_value,
                              data: q_data.data, notify: q_data.notify};
                  count <= count + 1'b1;
                end
              end
              CMD_CANCEL: begin
                if (q_data.null_owner) begin
                  cur_status <= ST_NULL_OWNER;
                end else begin
                  state <= S_SCAN;
                end
              end
              CMD_CHECK: state <= S_SCAN;
              default: count <= '0;
            endcase
          end
        end
        S_SCAN: begin
          if (rd == count) begin
            count <= wr;
            state <= S_CLOSE;
          end else if (can_load) begin
            if (hit && rd_slot.notify) begin
              res_valid <= 1'b1;
              kind <= (cur.op == CMD_CANCEL) ? KIND_CANCEL : KIND_EXPIRY;
              owner_out <= rd_slot.owner;
              fire_time <= (cur.op == CMD_CANCEL) ? 32'd0 : rd_slot.expiry;
              data_out <= rd_slot.data;
              status <= ST_OK;
              last <= 1'b0;
            end
            if (!hit) begin
              tbl[wr[IDX_W-1:0]] <= rd_slot;
              wr <= wr + 1'b1;
            end
            rd <= rd + 1'b1;
          end
        end
        S_CLOSE: begin
          if (can_load) begin
            res_valid <= 1'b1;
            kind <= KIND_CLOSE;
            owner_out <= 16'd0;
            fire_time <= 32'd0;
            data_out <= 32'd0;
            status <= cur_status;
            last <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/timer_expiry_table.sv */
// Add and clear pass through the command queue, the S_IDLE decode and the S_CLOSE state before their closing item.
// Cancel and check walk the stored timers (at most 16) one per cycle while the
// result side is not stalled, then give their closing item.
// A new command is taken only after the last has closed; a two-entry command queue decouples input.
// Reset (synchronous, active high) empties the table and the queue at once.
`timescale 1ns / 1ps
`default_nettype none
`include "timer_expiry_table_defines.svh"
module timer_expiry_table (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cmd_valid,
  output logic             cmd_ready,
  input  wire logic [1:0]  command,
  input  wire logic [15:0] owner,
  input  wire logic [31:0] time_value,
  input  wire logic        has_callback,
  input  wire logic [31:0] data_tag,
  output logic             res_valid,
  input  wire logic        res_ready,
  output logic [1:0]       kind,
  output logic [15:0]      owner_out,
  output logic [31:0]      fire_time,
  output logic [31:0]      data_out,
  output logic [1:0]       status,
  output logic             last
);
  import tet_pkg::*;

  logic q_valid;
  logic q_pop;
  cmd_t q_data;

  tet_front u_front (
    .clk(clk), .rst(rst), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
    .command(command), .owner(owner), .time_value(time_value),
    .has_callback(has_callback), .data_tag(data_tag),
    .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data)
  );

  tet_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data),
    .res_valid(res_valid), .res_ready(res_ready), .kind(kind),
    .owner_out(owner_out), .fire_time(fire_time), .data_out(data_out),
    .status(status), .last(last)
  );

  `TET_ASSERT(a_last_kind, clk, rst, res_valid |-> ((kind == KIND_CLOSE) == last))
  `TET_ASSERT(a_notice_ok, clk, rst, (res_valid && !last) |-> (status == ST_OK))
  `TET_ASSERT(a_cancel_time, clk, rst, (res_valid && kind == KIND_CANCEL) |-> (fire_time == 32'd0))
  `TET_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> !res_valid)
endmodule
`default_nettype wire
